// File: src/midpoint_circle_rasterizer_top_macros.svh
// Assertion macros used by the checker file mcr_checker.sv.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define MCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: src/mcr_pkg.sv
package mcr_pkg;

   localparam int SCREEN_HEIGHT = 600;
   localparam int MAX_RADIUS    = 1023;

   localparam logic [9:0] AXIS_OFFSET_RESET = 10'd200;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic REG_AXIS_OFFSET = 1'b0;

   localparam logic [2:0] LAST_PIXEL = 3'd7;

   typedef struct packed {
      logic signed [10:0] x;
      logic signed [10:0] y;
      logic signed [12:0] cx;
      logic signed [12:0] cy;
      logic        [3:0]  color;
      logic        [13:0] base;
      logic               done;
   } burst_type;

endpackage

// File: src/mcr_csr.sv
module mcr_csr
   import mcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [9:0]  axis_offset
);

   logic [9:0] offset_ff;
   logic [9:0] offset_in;

   always_comb begin
      offset_in = offset_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == REG_AXIS_OFFSET)) begin
         offset_in = csr_pwdata[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= AXIS_OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr == REG_AXIS_OFFSET) ? {22'd0, offset_ff} : 32'd0;
   assign axis_offset = offset_ff;

endmodule

// File: src/mcr_step.sv
module mcr_step
   import mcr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               cmd,
   input  logic signed [12:0] center_x,
   input  logic signed [12:0] center_y,
   input  logic        [9:0]  radius,
   input  logic        [3:0]  color,
   input  logic        [9:0]  axis_offset,
   output logic               launch,
   output burst_type          burst
);

   logic signed [10:0] x_ff, x_in;
   logic signed [10:0] y_ff, y_in;
   logic signed [13:0] d_ff, d_in;
   logic signed [12:0] cx_ff, cx_in;
   logic signed [12:0] cy_ff, cy_in;
   logic        [3:0]  color_ff, color_in;
   logic               active_ff, active_in;

   logic [9:0]  r_sat;
   logic [11:0] diff;
   logic [13:0] x4;
   logic        done;

   always_comb begin
      r_sat = ({1'b0, radius} > 11'(MAX_RADIUS)) ? 10'(MAX_RADIUS) : radius;
      x4    = {x_ff[10], x_ff, 2'b00};
      diff  = {x_ff[10], x_ff} - {y_ff[10], y_ff};
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      color_in  = color_ff;
      active_in = active_ff;
      launch    = 1'b0;
      done      = 1'b0;
      if (accept) begin
         if (cmd == CMD_START) begin
            cx_in     = center_x;
            cy_in     = center_y;
            color_in  = color;
            x_in      = 11'sd0;
            y_in      = signed'({1'b0, r_sat});
            d_in      = signed'(14'd3 - {3'b000, r_sat, 1'b0});
            active_in = 1'b1;
         end else if (active_ff) begin
            if (y_ff < x_ff) begin
               active_in = 1'b0;
            end else begin
               launch = 1'b1;
               if (d_ff < 0) begin
                  d_in = signed'(d_ff + x4 + 14'd6);
               end else begin
                  d_in = signed'(d_ff + {diff, 2'b00} + 14'd10);
                  y_in = y_ff - 11'sd1;
               end
               x_in = x_ff + 11'sd1;
               done = (y_in < x_in);
               if (done) begin
                  active_in = 1'b0;
               end
            end
         end
      end
      burst.x     = x_ff;
      burst.y     = y_ff;
      burst.cx    = cx_ff;
      burst.cy    = cy_ff;
      burst.color = color_ff;
      burst.base  = 14'(SCREEN_HEIGHT) - {4'd0, axis_offset};
      burst.done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= '0;
         y_ff      <= '0;
         d_ff      <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         color_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         d_ff      <= d_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         color_ff  <= color_in;
         active_ff <= active_in;
      end
   end

endmodule

// File: src/mcr_emit.sv
module mcr_emit
   import mcr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               launch,
   input  burst_type          burst,
   input  logic               rsp_stall,
   output logic               busy,
   output logic               finishing,
   output logic               rsp_valid,
   output logic signed [13:0] rsp_pixel_x,
   output logic signed [13:0] rsp_pixel_y,
   output logic        [3:0]  rsp_pixel_color,
   output logic               rsp_circle_done,
   output logic               rsp_last
);

   burst_type  burst_ff, burst_in;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;

   logic signed [10:0] a, b;
   logic signed [13:0] a14, b14, dx, dy, cx14, cy14;

   always_comb begin
      finishing = busy_ff && (idx_ff == LAST_PIXEL) && !rsp_stall;
      burst_in  = burst_ff;
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      if (launch) begin
         burst_in = burst;
         busy_in  = 1'b1;
         idx_in   = 3'd0;
      end else if (busy_ff && !rsp_stall) begin
         if (idx_ff == LAST_PIXEL) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_comb begin
      a    = idx_ff[0] ? burst_ff.y : burst_ff.x;
      b    = idx_ff[0] ? burst_ff.x : burst_ff.y;
      a14  = {{3{a[10]}}, a};
      b14  = {{3{b[10]}}, b};
      dx   = idx_ff[1] ? -a14 : a14;
      dy   = idx_ff[2] ? -b14 : b14;
      cx14 = {burst_ff.cx[12], burst_ff.cx};
      cy14 = {burst_ff.cy[12], burst_ff.cy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

   assign busy            = busy_ff;
   assign rsp_valid       = busy_ff;
   assign rsp_pixel_x     = cx14 + dx;
   assign rsp_pixel_y     = signed'(burst_ff.base) - (cy14 + dy);
   assign rsp_pixel_color = burst_ff.color;
   assign rsp_last        = (idx_ff == LAST_PIXEL);
   assign rsp_circle_done = burst_ff.done && (idx_ff == LAST_PIXEL);

endmodule

// File: src/midpoint_circle_rasterizer_top.sv
// Midpoint circle rasterizer.
// Request channel (req_valid / req_stall): a start beat (cmd 0) loads the
// center, radius and color; a step beat (cmd 1) plots the eight symmetric
// pixels of the current octant point and advances it.
// Response channel (rsp_valid / rsp_stall): one pixel per beat, with rsp_last
// on the eighth pixel of a step and rsp_circle_done on the final pixel.
// The first pixel of a step appears in the cycle after the step is taken, and
// the eight pixels follow on consecutive cycles while the receiver does not
// stall. A step that plots occupies the pixel sequencer until its eighth
// pixel is taken, and the next request is taken in that same cycle. Start
// beats and steps that plot nothing do not occupy the sequencer.
// While the receiver stalls, the current pixel holds and the request side
// stalls once a step burst is waiting.
// Reset clears the circle state, leaves the rasterizer idle with no pixel
// pending, and sets axis_offset to 200. The CSR port holds axis_offset at
// address 0 and should only be written while the block is idle.
module midpoint_circle_rasterizer_top
   import mcr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [12:0] req_center_x,
   input  logic signed [12:0] req_center_y,
   input  logic        [9:0]  req_radius,
   input  logic        [3:0]  req_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_pixel_x,
   output logic signed [13:0] rsp_pixel_y,
   output logic        [3:0]  rsp_pixel_color,
   output logic               rsp_circle_done,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic               csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic      [9:0] axis_offset;
   logic            accept;
   logic            launch;
   logic            busy;
   logic            finishing;
   burst_type       burst;

   assign req_stall = busy && !finishing;
   assign accept    = req_valid && !req_stall;

   mcr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .axis_offset (axis_offset)
   );

   mcr_step u_step (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_cmd),
      .center_x    (req_center_x),
      .center_y    (req_center_y),
      .radius      (req_radius),
      .color       (req_color),
      .axis_offset (axis_offset),
      .launch      (launch),
      .burst       (burst)
   );

   mcr_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .launch          (launch),
      .burst           (burst),
      .rsp_stall       (rsp_stall),
      .busy            (busy),
      .finishing       (finishing),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_circle_done (rsp_circle_done),
      .rsp_last        (rsp_last)
   );

endmodule

// File: src/mcr_checker.sv
`include "midpoint_circle_rasterizer_top_macros.svh"

module mcr_checker
   import mcr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [13:0] rsp_pixel_x,
   input logic signed [13:0] rsp_pixel_y,
   input logic               rsp_circle_done,
   input logic               rsp_last,
   input logic               csr_pready
);

   // A whole circle ends only on the closing pixel of a step.
   `MCR_ASSERT_SAME(done_on_last, clock, reset, rsp_valid && rsp_circle_done, rsp_last)

   // Pixels of a step burst follow one another without a gap.
   `MCR_ASSERT_NEXT(burst_unbroken, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid)

   // A pending burst holds its pixel while the receiver stalls.
   `MCR_ASSERT_NEXT(stall_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y))

   // Reset leaves no pixel pending and the register port ready.
   `MCR_ASSERT_NEXT(reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall && csr_pready)

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_circle_done (rsp_circle_done),
   .rsp_last        (rsp_last),
   .csr_pready      (csr_pready)
);
